@@ rtl/core/qbt_pkg.sv @@
// ----------------------------------------------------------------------------
// qbt_pkg: shared types and constants of the quoted brace tokenizer
// Character codes, scan modes, token kinds, the result record and the
// token length limits.
// ----------------------------------------------------------------------------
package qbt_pkg;

  // Token storage the tokenizer models; the usable limit is one less
  localparam int unsigned TOKEN_BUFFER = 1024;

  localparam int unsigned LEN_W = 10;
  localparam int unsigned DEPTH_W = 8;

  localparam int unsigned LIMIT_CAP_INT =
    (TOKEN_BUFFER - 1 > (1 << LEN_W) - 1) ? (1 << LEN_W) - 1 : TOKEN_BUFFER - 1;
  localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(LIMIT_CAP_INT);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1023);

  // Result queue: room for two items' worth of results
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW = $clog2(RQ_DEPTH);

  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_QUOTE,
    MODE_ESCAPE
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_WORD,
    KIND_STRING,
    KIND_OPEN,
    KIND_CLOSE
  } token_kind_e;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               has_byte;
    logic               token_end;
    token_kind_e        kind;
    logic               truncated;
    logic [DEPTH_W-1:0] depth;
    logic               brace_error;
    logic               last;
  } res_t;

  // Build one result; depth and last are filled in once the item is done
  function automatic res_t mk_res(logic [7:0] b, logic has, logic tend,
                                  token_kind_e kind, logic trunc, logic err);
    res_t r;
    r.out_byte    = has ? b : 8'h00;
    r.has_byte    = has;
    r.token_end   = tend;
    r.kind        = kind;
    r.truncated   = trunc;
    r.depth       = '0;
    r.brace_error = err;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/quoted_brace_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// quoted_brace_tokenizer_top: streaming tokenizer for braces and quoted strings
// Takes one character per item, emits token bytes and token ends with their
// kind, tracks brace nesting depth and flags truncated tokens.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o | char_in_i, end_of_input_i
//  out     | output    | out_valid_o/out_stall_i | out_byte_o .. last_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (max token length)
//
// An item waits in the input register until the queue has room and is then
// scanned into zero, one or two results in a four-entry result queue. The
// single output port drains one result per cycle while out_stall_i is low,
// so items of up to one result flow at one per cycle; two-result items stall.
// Reset clears the scan state, depth, queue and sets the length limit to 1023.
// in_stall_o rises only when the queue lacks room for two more results.
// ----------------------------------------------------------------------------
module quoted_brace_tokenizer_top
  import qbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_in_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               has_byte_o,
  output logic               token_end_o,
  output logic [1:0]         token_kind_o,
  output logic               truncated_o,
  output logic [DEPTH_W-1:0] brace_depth_o,
  output logic               brace_error_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LEN_W-1:0]   cfg_data_i
);

  logic [LEN_W-1:0]   max_len_q;
  logic               item_vld_q, item_vld_d;
  logic [7:0]         char_q;
  logic               eoi_q;
  scan_mode_e         mode_q, mode_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               ovf_q, ovf_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  res_t               rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [RQ_AW:0]     cnt_q, cnt_d;
  logic               in_acc, proc, pop;
  logic [LEN_W-1:0]   lim;
  res_t [1:0]         res_v;
  logic [1:0]         n_v;
  logic [1:0]         push_n;
  res_t               head;

  // Configuration register: always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign lim = (max_len_q > LIMIT_CAP) ? LIMIT_CAP : max_len_q;

  // Input register handshake
  assign proc       = item_vld_q && (cnt_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign in_stall_o = item_vld_q && !proc;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_acc) begin
      item_vld_d = 1'b1;
    end else if (proc) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= char_in_i;
      eoi_q  <= end_of_input_i;
    end
  end

  // Scan one item: next state and up to two results
  always_comb begin : scan
    logic is_space;
    logic is_brace;
    logic err;
    mode_d   = mode_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    depth_d  = depth_q;
    n_v      = 2'd0;
    res_v    = '0;
    err      = 1'b0;
    is_space = (char_q == CHAR_SPACE) || ((char_q >= CHAR_TAB) && (char_q <= CHAR_CR));
    is_brace = (char_q == CHAR_LBRACE) || (char_q == CHAR_RBRACE);

    if (eoi_q) begin
      case (mode_q)
        MODE_WORD, MODE_QUOTE: begin
          res_v[n_v[0]] = mk_res(8'h00, 1'b0, 1'b1,
                                 (mode_q == MODE_WORD) ? KIND_WORD : KIND_STRING,
                                 ovf_d, 1'b0);
          n_v = n_v + 2'd1;
        end
        MODE_ESCAPE: begin
          // Flush the pending backslash with the token end if it fits
          if (len_d < lim) begin
            res_v[n_v[0]] = mk_res(CHAR_BSLASH, 1'b1, 1'b1, KIND_STRING, ovf_d, 1'b0);
          end else begin
            res_v[n_v[0]] = mk_res(8'h00, 1'b0, 1'b1, KIND_STRING, 1'b1, 1'b0);
          end
          n_v = n_v + 2'd1;
        end
        default: begin
        end
      endcase
      mode_d = MODE_IDLE;
      len_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (is_space) begin
          end else if (char_q == CHAR_QUOTE) begin
            mode_d = MODE_QUOTE;
          end else if (!is_brace) begin
            mode_d = MODE_WORD;
            if (len_d < lim) begin
              len_d = len_d + LEN_W'(1);
              res_v[n_v[0]] = mk_res(char_q, 1'b1, 1'b0, KIND_WORD, 1'b0, 1'b0);
              n_v = n_v + 2'd1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        MODE_WORD: begin
          if (is_space || is_brace) begin
            res_v[n_v[0]] = mk_res(8'h00, 1'b0, 1'b1, KIND_WORD, ovf_d, 1'b0);
            n_v    = n_v + 2'd1;
            mode_d = MODE_IDLE;
            len_d  = '0;
            ovf_d  = 1'b0;
          end else if (len_d < lim) begin
            len_d = len_d + LEN_W'(1);
            res_v[n_v[0]] = mk_res(char_q, 1'b1, 1'b0, KIND_WORD, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        MODE_QUOTE: begin
          if (char_q == CHAR_QUOTE) begin
            res_v[n_v[0]] = mk_res(8'h00, 1'b0, 1'b1, KIND_STRING, ovf_d, 1'b0);
            n_v    = n_v + 2'd1;
            mode_d = MODE_IDLE;
            len_d  = '0;
            ovf_d  = 1'b0;
          end else if (char_q == CHAR_BSLASH) begin
            mode_d = MODE_ESCAPE;
          end else if (len_d < lim) begin
            len_d = len_d + LEN_W'(1);
            res_v[n_v[0]] = mk_res(char_q, 1'b1, 1'b0, KIND_STRING, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          // Keep the backslash unless it escapes a quote
          if (char_q != CHAR_QUOTE) begin
            if (len_d < lim) begin
              len_d = len_d + LEN_W'(1);
              res_v[n_v[0]] = mk_res(CHAR_BSLASH, 1'b1, 1'b0, KIND_STRING, 1'b0, 1'b0);
              n_v = n_v + 2'd1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (len_d < lim) begin
            len_d = len_d + LEN_W'(1);
            res_v[n_v[0]] = mk_res(char_q, 1'b1, 1'b0, KIND_STRING, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
          end else begin
            ovf_d = 1'b1;
          end
          mode_d = MODE_QUOTE;
        end
        default: begin
        end
      endcase

      // Brace token outside quotes, after any word end
      if (is_brace && ((mode_q == MODE_IDLE) || (mode_q == MODE_WORD))) begin
        if (char_q == CHAR_LBRACE) begin
          if (depth_d != {DEPTH_W{1'b1}}) begin
            depth_d = depth_d + DEPTH_W'(1);
          end
          res_v[n_v[0]] = mk_res(char_q, 1'b1, 1'b1, KIND_OPEN, 1'b0, 1'b0);
        end else begin
          err = (depth_d == '0);
          if (!err) begin
            depth_d = depth_d - DEPTH_W'(1);
          end
          res_v[n_v[0]] = mk_res(char_q, 1'b1, 1'b1, KIND_CLOSE, 1'b0, err);
        end
        n_v = n_v + 2'd1;
      end
    end

    // Stamp depth after the item and mark its final result
    res_v[0].depth = depth_d;
    res_v[1].depth = depth_d;
    res_v[0].last  = (n_v == 2'd1);
    res_v[1].last  = (n_v == 2'd2);
  end

  // Scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      depth_q <= '0;
    end else if (proc) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      depth_q <= depth_d;
    end
  end

  // Result queue: push up to two, pop one per cycle unless out_stall_i is high
  assign push_n      = proc ? n_v : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_d       = cnt_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      rq_mem[wr_ptr_q] <= res_v[0];
    end
    if (push_n == 2'd2) begin
      rq_mem[wr_ptr_q + RQ_AW'(1)] <= res_v[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RQ_AW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Drive the output fields from the queue head
  assign head          = rq_mem[rd_ptr_q];
  assign out_byte_o    = head.out_byte;
  assign has_byte_o    = head.has_byte;
  assign token_end_o   = head.token_end;
  assign token_kind_o  = head.kind;
  assign truncated_o   = head.truncated;
  assign brace_depth_o = head.depth;
  assign brace_error_o = head.brace_error;
  assign last_o        = head.last;

endmodule

@@ rtl/core/qbt_checker.sv @@
// ----------------------------------------------------------------------------
// qbt_checker: port-level checks for the quoted brace tokenizer
// Watches the output channel and the meaning of the result fields.
// ----------------------------------------------------------------------------
module qbt_checker
  import qbt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         out_byte_o,
  input logic               has_byte_o,
  input logic               token_end_o,
  input logic [1:0]         token_kind_o,
  input logic               truncated_o,
  input logic [DEPTH_W-1:0] brace_depth_o,
  input logic               brace_error_o,
  input logic               last_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(token_end_o) && $stable(token_kind_o) && $stable(last_o))
    else $error("stalled result changed");

  // Brace tokens carry their byte and end at once
  a_brace_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_OPEN || token_kind_o == KIND_CLOSE)
      |-> has_byte_o && token_end_o && !truncated_o)
    else $error("brace token without byte or end");

  // Brace error only on a close brace that leaves depth at zero
  a_brace_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brace_error_o
      |-> token_kind_o == KIND_CLOSE && brace_depth_o == '0)
    else $error("brace error on wrong result");

  // A result without a byte is a token end with a zero byte
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> token_end_o && out_byte_o == 8'h00)
    else $error("empty result that ends no token");

  // Truncation is reported only at a token end
  a_trunc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> token_end_o)
    else $error("truncation flag outside token end");

endmodule

bind quoted_brace_tokenizer_top qbt_checker u_qbt_checker (.*);
